// ----- rtl/lrups_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lrups_pkg;

	localparam int MAX_WAYS  = 8;
	localparam int PAGE_BITS = 16;

	// field widths fixed at the ports
	localparam int PAGE_FIELD_BITS = 16;
	localparam int CFG_BITS        = 4;
	localparam int IN_TDATA_BITS   = 16;
	localparam int OUT_TDATA_BITS  = 24;

	localparam int IDX_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	// frame count after reset is 8, clipped to the slots built
	localparam int RESET_WAYS = (8 > MAX_WAYS) ? MAX_WAYS : 8;
	localparam logic [IDX_BITS-1:0] RESET_TOP = IDX_BITS'(RESET_WAYS - 1);

	typedef logic [PAGE_BITS-1:0] page_t;

	// contents of one slot, passed down the row
	typedef struct packed {
		page_t page;
		logic  valid;
	} slot_t;

	// per-request controls broadcast to every cell
	typedef struct packed {
		logic  load;
		logic  hit;
		logic  clear;
		page_t ref_page;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lru_page_replacement_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none

// LRU recency stack of page numbers, one request per clock unless the output
// stalls. A row of cells holds the resident pages from least recent (cell 0)
// to most recent (the top cell, set by ways_in_use). Every cell compares the
// request against its page in the same cycle; on a hit the matching entry
// and those above it shift down and the page goes to the top, on a miss the
// whole row shifts and cell 0 is evicted. Each request yields one response;
// the result register decouples the sides, so requests stream at one per
// clock while the response is taken. The longest path is the match ripple
// through all cells. tlast on a request empties the stack after that
// request. A cfg_we write sets the frame count (0 reads as 1, above the slot
// count as the slot count) and empties the stack.

module lru_page_replacement_stack (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [lrups_pkg::CFG_BITS-1:0]       cfg_wdata,   // ways_in_use
	input  wire logic                                 s_tvalid,
	output      logic                                 s_tready,
	input  wire logic [lrups_pkg::IN_TDATA_BITS-1:0]  s_tdata,     // [15:0] page_number
	input  wire logic                                 s_tlast,     // end_of_run
	output      logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	output      logic [lrups_pkg::OUT_TDATA_BITS-1:0] m_tdata      // [0] hit,
	                                                               // [1] victim_valid,
	                                                               // [17:2] victim_page
);

	localparam int N  = lrups_pkg::MAX_WAYS;
	localparam int IB = lrups_pkg::IDX_BITS;

	logic [IB-1:0]        top_q;
	logic [IB-1:0]        top_next;
	logic                 accept;
	logic                 hit;
	logic                 victim_valid;
	lrups_pkg::page_t     victim_page;
	lrups_pkg::cell_ctl_t ctl;
	lrups_pkg::slot_t     slots [N];
	logic                 match_chain [N+1];

	logic                                           m_tvalid_q;
	logic                                           hit_q;
	logic                                           victim_valid_q;
	logic [lrups_pkg::PAGE_FIELD_BITS-1:0]          victim_page_q;

	// clamp the written frame count to 1..N and keep the top slot index
	always_comb begin
		if (cfg_wdata == '0) begin
			top_next = '0;
		end else if (32'(cfg_wdata) > N) begin
			top_next = IB'(N - 1);
		end else begin
			top_next = IB'(cfg_wdata - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= lrups_pkg::RESET_TOP;
		end else if (cfg_we) begin
			top_q <= top_next;
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign match_chain[0] = 1'b0;
	assign hit            = match_chain[N];

	assign ctl.load     = accept;
	assign ctl.hit      = hit;
	assign ctl.clear    = cfg_we || (accept && s_tlast);
	assign ctl.ref_page = lrups_pkg::PAGE_BITS'(s_tdata);

	for (genvar i = 0; i < N; i++) begin : g_cell
		lrups_pkg::slot_t upper;

		if (i == N - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid
			assign upper = slots[i+1];
		end

		lrups_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.active    (IB'(i) <= top_q),
			.is_top    (IB'(i) == top_q),
			.upper     (upper),
			.match_in  (match_chain[i]),
			.match_out (match_chain[i+1]),
			.slot      (slots[i])
		);
	end

	assign victim_valid = !hit && slots[0].valid;
	assign victim_page  = victim_valid ? slots[0].page : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q          <= hit;
			victim_valid_q <= victim_valid;
			victim_page_q  <= lrups_pkg::PAGE_FIELD_BITS'(victim_page);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = lrups_pkg::OUT_TDATA_BITS'({victim_page_q, victim_valid_q, hit_q});

endmodule

`default_nettype wire

// ----- rtl/lrups_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lrups_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lrups_pkg::cell_ctl_t  ctl,
	input  wire logic                  active,
	input  wire logic                  is_top,
	input  wire lrups_pkg::slot_t      upper,
	input  wire logic                  match_in,
	output      logic                  match_out,
	output      lrups_pkg::slot_t      slot
);

	lrups_pkg::page_t page_q;
	logic             valid_q;
	logic             match_here;
	logic             take_upper;

	assign match_here = active && valid_q && (page_q == ctl.ref_page);
	assign match_out  = match_in | match_here;

	// on a miss every active slot shifts; on a hit only the active slots at and above the match
	assign take_upper = active && (!ctl.hit || match_out);

	assign slot.page  = page_q;
	assign slot.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			if (is_top) begin
				valid_q <= 1'b1;
			end else if (take_upper) begin
				valid_q <= upper.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (is_top) begin
				page_q <= ctl.ref_page;
			end else if (take_upper) begin
				page_q <= upper.page;
			end
		end
	end

endmodule

`default_nettype wire

// ----- tb/sv/lru_page_replacement_stack_tb.sv -----
`timescale 1ns / 1ps

module lru_page_replacement_stack_tb;
	import lrups_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int N_PHASES    = 12;
	localparam int PHASE_REFS  = 53;

	typedef struct {
		logic [PAGE_FIELD_BITS-1:0] page;
		logic                       last;
	} page_ref_t;

	typedef struct packed {
		logic [PAGE_FIELD_BITS-1:0] victim_page;
		logic                       victim_valid;
		logic                       hit;
	} lru_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_BITS-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_tdata;

	page_ref_t    ref_q[$];
	lru_outcome_t outcome_q[$];
	int           refs_queued = 0;
	int           refs_taken = 0;
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	int           send_idle_pct = 10;
	int           recv_idle_pct = 69;
	logic         req_accepted = 1'b0;

	// predictor state: slot 0 is least recent
	logic [PAGE_BITS-1:0] lru_page [MAX_WAYS];
	logic                 lru_ok [MAX_WAYS];
	logic [CFG_BITS-1:0]  frame_setting;

	lru_page_replacement_stack u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void clear_lru();
		int j;
		for (j = 0; j < MAX_WAYS; j++) begin
			lru_page[j] = '0;
			lru_ok[j] = 1'b0;
		end
	endfunction

	function automatic lru_outcome_t lru_reference(input logic [PAGE_BITS-1:0] pg,
			input logic end_run);
		lru_outcome_t r;
		int k;
		int top;
		int at;
		int j;
		logic found;
		if (frame_setting == 0)
			k = 1;
		else if (frame_setting > MAX_WAYS)
			k = MAX_WAYS;
		else
			k = frame_setting;
		top = k - 1;
		found = 1'b0;
		at = 0;
		for (j = 0; j < k; j++) begin
			if (!found && lru_ok[j] && lru_page[j] == pg) begin
				found = 1'b1;
				at = j;
			end
		end
		r = '0;
		r.hit = found;
		if (!found && lru_ok[0]) begin
			r.victim_valid = 1'b1;
			r.victim_page = lru_page[0];
		end
		// miss shifts the whole row, hit shifts only above the match
		for (j = at; j < top; j++) begin
			lru_page[j] = lru_page[j + 1];
			lru_ok[j] = lru_ok[j + 1];
		end
		lru_page[top] = pg;
		lru_ok[top] = 1'b1;
		if (end_run)
			clear_lru();
		return r;
	endfunction

	// request driver
	always @(negedge clk) begin
		page_ref_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_accepted) begin
			if (ref_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = ref_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.page;
				s_tlast <= nxt.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		lru_outcome_t want;
		if (!arst_n) begin
			req_accepted <= 1'b0;
			frame_setting = CFG_BITS'(8);
			clear_lru();
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata=%h",
						$time, m_tdata);
					mismatch_count++;
				end else begin
					want = outcome_q.pop_front();
					if (m_tdata[0] !== want.hit || m_tdata[1] !== want.victim_valid ||
							m_tdata[17:2] !== want.victim_page ||
							m_tdata[OUT_TDATA_BITS-1:18] !== '0) begin
						$display("%0t: expected hit=%0b victim_valid=%0b victim_page=%h pad=0, actual hit=%0b victim_valid=%0b victim_page=%h pad=%h",
							$time, want.hit, want.victim_valid, want.victim_page,
							m_tdata[0], m_tdata[1], m_tdata[17:2],
							m_tdata[OUT_TDATA_BITS-1:18]);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				outcome_q.push_back(lru_reference(s_tdata[PAGE_BITS-1:0], s_tlast));
				refs_taken++;
			end
			req_accepted <= s_tvalid && s_tready;
			if (cfg_we) begin
				frame_setting = cfg_wdata;
				clear_lru();
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic push_ref(input logic [PAGE_FIELD_BITS-1:0] pg, input logic last);
		page_ref_t r;
		r.page = pg;
		r.last = last;
		ref_q.push_back(r);
		refs_queued++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (refs_taken != refs_queued || outcome_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_BITS-1:0] v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// references drawn mostly from a small working set so hits and
	// evictions both stay frequent
	task automatic random_refs(input int n);
		logic [PAGE_FIELD_BITS-1:0] hot [12];
		int hot_n;
		int i;
		hot_n = $urandom_range(2, 12);
		for (i = 0; i < 12; i++)
			hot[i] = PAGE_FIELD_BITS'($urandom);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 85)
				push_ref(hot[$urandom_range(hot_n - 1)], $urandom_range(99) < 4);
			else
				push_ref(PAGE_FIELD_BITS'($urandom), $urandom_range(99) < 4);
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] frame_plan [N_PHASES];
		int ph;
		frame_plan = '{4'd1, 4'd15, 4'd8, 4'd3, 4'd0, 4'd6, 4'd2, 4'd9, 4'd4,
			4'd7, 4'd5, 4'd8};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset frame count of eight: fill, evict, middle hit, end of run
		push_ref(16'h0000, 1'b0);
		push_ref(16'hFFFF, 1'b0);
		push_ref(16'h0000, 1'b0);
		for (int p = 1; p <= 6; p++)
			push_ref(PAGE_FIELD_BITS'(p), 1'b0);
		push_ref(16'h0007, 1'b0);
		push_ref(16'hFFFF, 1'b0);
		push_ref(16'h0005, 1'b0);
		push_ref(16'h0003, 1'b1);
		push_ref(16'h0003, 1'b0);
		wait_drained();

		// zero frames reads as one
		write_frames('0);
		push_ref(16'hAAAA, 1'b0);
		push_ref(16'hAAAA, 1'b0);
		push_ref(16'h5555, 1'b0);
		push_ref(16'h5555, 1'b1);
		push_ref(16'h1234, 1'b0);
		wait_drained();

		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 10;
				recv_idle_pct = 69;
			end else if (ph < 8) begin
				send_idle_pct = 69;
				recv_idle_pct = 10;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_frames(frame_plan[ph]);
			if (ph % 4 == 1) begin
				// sender holds off until every result is back
				random_refs(PHASE_REFS / 2);
				wait_drained();
				repeat ($urandom_range(5, 20)) @(negedge clk);
				random_refs(PHASE_REFS - PHASE_REFS / 2);
			end else begin
				random_refs(PHASE_REFS);
			end
			wait_drained();
		end

		repeat (5) @(negedge clk);
		if (mismatch_count == 0 && outcome_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- lru_page_replacement_stack.f -----
rtl/lrups_pkg.sv
rtl/lrups_cell.sv
rtl/lru_page_replacement_stack.sv
tb/sv/lru_page_replacement_stack_tb.sv
